FILE: src/plob_pkg.sv
// Shared types and constants for the price-level order book.
`default_nettype none
package plob_pkg;

    // Default number of price levels held on each side of the book.
    localparam int unsigned LOB_LEVELS = 64;

    localparam int unsigned PRICE_W = 32;
    localparam int unsigned VOL_W   = 32;
    localparam int unsigned INST_W  = 32;

    typedef enum logic [1:0] {
        ST_APPLIED = 2'd0,
        ST_FULL    = 2'd1,
        ST_ABSENT  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        STG_IDLE,
        STG_CMP,
        STG_APPLY
    } t_stage;

    // Operation broadcast to every cell of one side during the apply cycle.
    typedef struct packed {
        logic ins;
        logic del;
        logic upd;
    } t_cell_op;

    // Search outcome of one side, taken from the registered cell flags.
    typedef struct packed {
        logic hit;
        logic full;
    } t_side_flags;

endpackage
`default_nettype wire

FILE: src/price_level_order_book_top.sv
// Top level of the price-level order book: control, both sides and result register.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------------
//  input    | i_in_valid / o_in_ready    | i_side, i_price, i_volume
//  result   | o_out_valid / i_out_ready  | o_status, best bid/ask, o_instrument_out
//  config   | i_cfg_we                   | i_cfg_wdata
//
// Each transaction has a compare cycle, in which every cell compares its level
// with the new price, and an apply cycle, in which the row shifts or updates in place.
// A new transaction is taken when idle, or in the apply cycle while the last one is applied.
// The apply cycle waits while the result register is full and not being taken.
// Reset is synchronous and empties both sides; no clearing pass is needed.
`default_nettype none
module price_level_order_book_top #(
    parameter int unsigned LEVELS = plob_pkg::LOB_LEVELS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic                        i_side,
    input  wire logic [plob_pkg::PRICE_W-1:0] i_price,
    input  wire logic [plob_pkg::VOL_W-1:0]   i_volume,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [1:0]                       o_status,
    output logic                             o_bid_present,
    output logic [plob_pkg::PRICE_W-1:0]      o_best_bid_price,
    output logic [plob_pkg::VOL_W-1:0]        o_best_bid_volume,
    output logic                             o_ask_present,
    output logic [plob_pkg::PRICE_W-1:0]      o_best_ask_price,
    output logic [plob_pkg::VOL_W-1:0]        o_best_ask_volume,
    output logic [plob_pkg::INST_W-1:0]       o_instrument_out,
    input  wire logic                        i_cfg_we,
    input  wire logic [plob_pkg::INST_W-1:0]  i_cfg_wdata
);
    import plob_pkg::*;

    t_stage             r_stage, n_stage;
    logic               r_side;
    logic [PRICE_W-1:0] r_price;
    logic [VOL_W-1:0]   r_volume;
    logic [INST_W-1:0]  r_inst;
    logic               in_acc, out_free, cmp_en, apply_go;
    t_side_flags        bid_flags, ask_flags, sel_flags;
    logic               bid_present, ask_present;
    logic [PRICE_W-1:0] bid_price, ask_price;
    logic [VOL_W-1:0]   bid_vol, ask_vol;
    t_status            status;

    logic               r_out_valid;
    t_status            r_status;
    logic               r_bid_present, r_ask_present;
    logic [PRICE_W-1:0] r_bid_price, r_ask_price;
    logic [VOL_W-1:0]   r_bid_vol, r_ask_vol;
    logic [INST_W-1:0]  r_inst_out;

    assign out_free = !r_out_valid || i_out_ready;
    assign in_acc   = i_in_valid && o_in_ready;

    always_comb begin
        n_stage = r_stage;
        case (r_stage)
            STG_IDLE: begin
                if (in_acc) begin
                    n_stage = STG_CMP;
                end
            end
            STG_CMP: begin
                n_stage = STG_APPLY;
            end
            STG_APPLY: begin
                if (out_free) begin
                    n_stage = in_acc ? STG_CMP : STG_IDLE;
                end
            end
            default: begin
                n_stage = STG_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        cmp_en     = 1'b0;
        apply_go   = 1'b0;
        case (r_stage)
            STG_IDLE: begin
                o_in_ready = 1'b1;
            end
            STG_CMP: begin
                cmp_en = 1'b1;
            end
            STG_APPLY: begin
                apply_go   = out_free;
                o_in_ready = out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= STG_IDLE;
            r_inst  <= '0;
        end else begin
            r_stage <= n_stage;
            if (i_cfg_we) begin
                r_inst <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_side   <= i_side;
            r_price  <= i_price;
            r_volume <= i_volume;
        end
    end

    // Bids are kept in descending order so that the best level of either side
    // always sits in the first cell.
    plob_chain #(
        .LEVELS  (LEVELS),
        .DESCEND (1'b1)
    ) u_bid (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmp_en         (cmp_en && !r_side),
        .i_apply          (apply_go && !r_side),
        .i_price          (r_price),
        .i_volume         (r_volume),
        .o_flags          (bid_flags),
        .o_nxt_present    (bid_present),
        .o_nxt_best_price (bid_price),
        .o_nxt_best_vol   (bid_vol)
    );

    plob_chain #(
        .LEVELS  (LEVELS),
        .DESCEND (1'b0)
    ) u_ask (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmp_en         (cmp_en && r_side),
        .i_apply          (apply_go && r_side),
        .i_price          (r_price),
        .i_volume         (r_volume),
        .o_flags          (ask_flags),
        .o_nxt_present    (ask_present),
        .o_nxt_best_price (ask_price),
        .o_nxt_best_vol   (ask_vol)
    );

    assign sel_flags = r_side ? ask_flags : bid_flags;

    always_comb begin
        status = ST_APPLIED;
        if (!sel_flags.hit) begin
            if (r_volume == '0) begin
                status = ST_ABSENT;
            end else if (sel_flags.full) begin
                status = ST_FULL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (apply_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (apply_go) begin
            r_status      <= status;
            r_bid_present <= bid_present;
            r_bid_price   <= bid_present ? bid_price : '0;
            r_bid_vol     <= bid_present ? bid_vol : '0;
            r_ask_present <= ask_present;
            r_ask_price   <= ask_present ? ask_price : '0;
            r_ask_vol     <= ask_present ? ask_vol : '0;
            r_inst_out    <= r_inst;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_bid_present     = r_bid_present;
    assign o_best_bid_price  = r_bid_price;
    assign o_best_bid_volume = r_bid_vol;
    assign o_ask_present     = r_ask_present;
    assign o_best_ask_price  = r_ask_price;
    assign o_best_ask_volume = r_ask_vol;
    assign o_instrument_out  = r_inst_out;

`ifndef NO_ASSERTIONS
    // An accepted transaction always moves on to the compare cycle.
    a_acc_to_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_stage == STG_CMP))
        else $error("accepted transaction did not enter the compare cycle");

    // The apply cycle holds while the result register cannot be refilled.
    a_apply_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stage == STG_APPLY && !out_free) |=> (r_stage == STG_APPLY))
        else $error("apply cycle left while the result register was blocked");

    // A fresh result only appears straight after an apply cycle.
    a_out_from_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_stage) == STG_APPLY))
        else $error("result raised without an apply cycle");
`endif

endmodule
`default_nettype wire

FILE: src/plob_cell.sv
// One price level: holds a price and volume and trades them with its neighbours.
`default_nettype none
module plob_cell #(
    parameter bit DESCEND = 1'b0
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cmp_en,
    input  wire logic                        i_valid,
    input  wire logic [plob_pkg::PRICE_W-1:0] i_price,
    input  wire logic [plob_pkg::VOL_W-1:0]   i_volume,
    input  wire plob_pkg::t_cell_op          i_op,
    input  wire logic                        i_prev_before,
    input  wire logic [plob_pkg::PRICE_W-1:0] i_prev_price,
    input  wire logic [plob_pkg::VOL_W-1:0]   i_prev_vol,
    input  wire logic [plob_pkg::PRICE_W-1:0] i_next_price,
    input  wire logic [plob_pkg::VOL_W-1:0]   i_next_vol,
    output logic                             o_before,
    output logic                             o_eq,
    output logic [plob_pkg::PRICE_W-1:0]      o_price,
    output logic [plob_pkg::VOL_W-1:0]        o_vol,
    output logic [plob_pkg::PRICE_W-1:0]      o_nxt_price,
    output logic [plob_pkg::VOL_W-1:0]        o_nxt_vol
);
    import plob_pkg::*;

    logic [PRICE_W-1:0] r_price, n_price;
    logic [VOL_W-1:0]   r_vol, n_vol;
    logic               r_before, r_eq;
    logic               cmp_before;

    // A level sorts ahead of the new price when it is strictly better.
    assign cmp_before = DESCEND ? (r_price > i_price) : (r_price < i_price);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_before <= 1'b0;
            r_eq     <= 1'b0;
        end else if (i_cmp_en) begin
            r_before <= i_valid && cmp_before;
            r_eq     <= i_valid && (r_price == i_price);
        end
    end

    always_comb begin
        n_price = r_price;
        n_vol   = r_vol;
        if (i_op.ins && !r_before) begin
            if (i_prev_before) begin
                n_price = i_price;
                n_vol   = i_volume;
            end else begin
                n_price = i_prev_price;
                n_vol   = i_prev_vol;
            end
        end
        if (i_op.del && !r_before) begin
            n_price = i_next_price;
            n_vol   = i_next_vol;
        end
        if (i_op.upd && r_eq) begin
            n_vol = i_volume;
        end
    end

    always_ff @(posedge i_clk) begin
        r_price <= n_price;
        r_vol   <= n_vol;
    end

    assign o_before    = r_before;
    assign o_eq        = r_eq;
    assign o_price     = r_price;
    assign o_vol       = r_vol;
    assign o_nxt_price = n_price;
    assign o_nxt_vol   = n_vol;

endmodule
`default_nettype wire

FILE: src/plob_chain.sv
// One side of the book: a sorted row of level cells, best level in cell zero.
`default_nettype none
module plob_chain #(
    parameter int unsigned LEVELS  = plob_pkg::LOB_LEVELS,
    parameter bit          DESCEND = 1'b0
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cmp_en,
    input  wire logic                        i_apply,
    input  wire logic [plob_pkg::PRICE_W-1:0] i_price,
    input  wire logic [plob_pkg::VOL_W-1:0]   i_volume,
    output plob_pkg::t_side_flags            o_flags,
    output logic                             o_nxt_present,
    output logic [plob_pkg::PRICE_W-1:0]      o_nxt_best_price,
    output logic [plob_pkg::VOL_W-1:0]        o_nxt_best_vol
);
    import plob_pkg::*;

    localparam int unsigned CW = $clog2(LEVELS + 1);

    logic [CW-1:0]      r_count, n_count;
    logic [LEVELS-1:0]  ahead, eq, valid;
    logic [PRICE_W-1:0] price [LEVELS];
    logic [VOL_W-1:0]   vol   [LEVELS];
    logic [PRICE_W-1:0] nxt_price0;
    logic [VOL_W-1:0]   nxt_vol0;
    logic               hit, full, vol_zero;
    t_cell_op           op;

    assign hit      = |eq;
    assign full     = (r_count == CW'(LEVELS));
    assign vol_zero = (i_volume == '0);

    always_comb begin
        op     = '0;
        op.del = i_apply && vol_zero && hit;
        op.upd = i_apply && !vol_zero && hit;
        op.ins = i_apply && !vol_zero && !hit && !full;
    end

    always_comb begin
        n_count = r_count;
        if (op.ins) begin
            n_count = r_count + CW'(1);
        end else if (op.del) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    for (genvar g = 0; g < LEVELS; g++) begin : g_cell
        logic               prev_before;
        logic [PRICE_W-1:0] prev_price, next_price, nxt_price;
        logic [VOL_W-1:0]   prev_vol, next_vol, nxt_vol;

        assign valid[g] = (CW'(g) < r_count);

        if (g == 0) begin : g_head
            assign prev_before = 1'b1;
            assign prev_price  = i_price;
            assign prev_vol    = i_volume;
            assign nxt_price0  = nxt_price;
            assign nxt_vol0    = nxt_vol;
        end else begin : g_body
            assign prev_before = ahead[g-1];
            assign prev_price  = price[g-1];
            assign prev_vol    = vol[g-1];
        end

        if (g == LEVELS - 1) begin : g_tail
            assign next_price = price[g];
            assign next_vol   = vol[g];
        end else begin : g_inner
            assign next_price = price[g+1];
            assign next_vol   = vol[g+1];
        end

        plob_cell #(
            .DESCEND (DESCEND)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmp_en      (i_cmp_en),
            .i_valid       (valid[g]),
            .i_price       (i_price),
            .i_volume      (i_volume),
            .i_op          (op),
            .i_prev_before (prev_before),
            .i_prev_price  (prev_price),
            .i_prev_vol    (prev_vol),
            .i_next_price  (next_price),
            .i_next_vol    (next_vol),
            .o_before      (ahead[g]),
            .o_eq          (eq[g]),
            .o_price       (price[g]),
            .o_vol         (vol[g]),
            .o_nxt_price   (nxt_price),
            .o_nxt_vol     (nxt_vol)
        );
    end

    always_comb begin
        o_flags      = '0;
        o_flags.hit  = hit;
        o_flags.full = full;
    end

    assign o_nxt_present    = (n_count != '0);
    assign o_nxt_best_price = nxt_price0;
    assign o_nxt_best_vol   = nxt_vol0;

endmodule
`default_nettype wire

FILE: verif/price_level_order_book_top_tb.sv
// Self-checking testbench for the price-level order book with a scoreboard and random handshakes.
`default_nettype none
module price_level_order_book_top_tb;
    import plob_pkg::*;

    localparam int unsigned DEPTH     = LOB_LEVELS;
    localparam int unsigned LIMIT     = 300000;
    localparam int unsigned LONG_HOLD = 300;
    localparam logic        SIDE_BID  = 1'b0;
    localparam logic        SIDE_ASK  = 1'b1;

    typedef logic [PRICE_W-1:0] price_t;
    typedef logic [VOL_W-1:0]   vol_t;
    typedef logic [INST_W-1:0]  inst_t;

    typedef struct packed {
        t_status status;
        logic    bid_present;
        price_t  bid_price;
        vol_t    bid_volume;
        logic    ask_present;
        price_t  ask_price;
        vol_t    ask_volume;
        inst_t   instrument;
    } snapshot_t;

    // Mirror of both sides of the book and the queue of snapshots still owed by the block.
    class book_scoreboard;
        price_t      lvl_price [2][DEPTH];
        vol_t        lvl_vol [2][DEPTH];
        int unsigned lvl_count [2] = '{0, 0};
        inst_t       instrument = '0;
        snapshot_t   pending[$];
        int unsigned errors = 0;
        int unsigned checked = 0;
        int unsigned orders = 0;
        int unsigned dropped_full = 0;
        int unsigned absent_deletes = 0;

        // Levels are kept in ascending price order on both sides.
        function t_status apply_level(logic s, price_t p, vol_t v);
            int unsigned pos;
            int unsigned n;
            bit hit;
            n = lvl_count[s];
            pos = 0;
            while (pos < n && lvl_price[s][pos] < p) pos++;
            hit = (pos < n) && (lvl_price[s][pos] == p);
            if (v == '0) begin
                if (!hit) return ST_ABSENT;
                for (int k = pos; k + 1 < n; k++) begin
                    lvl_price[s][k] = lvl_price[s][k+1];
                    lvl_vol[s][k]   = lvl_vol[s][k+1];
                end
                lvl_count[s] = n - 1;
                return ST_APPLIED;
            end
            if (hit) begin
                lvl_vol[s][pos] = v;
                return ST_APPLIED;
            end
            if (n >= DEPTH) return ST_FULL;
            for (int k = n; k > pos; k--) begin
                lvl_price[s][k] = lvl_price[s][k-1];
                lvl_vol[s][k]   = lvl_vol[s][k-1];
            end
            lvl_price[s][pos] = p;
            lvl_vol[s][pos]   = v;
            lvl_count[s]      = n + 1;
            return ST_APPLIED;
        endfunction

        function void note_order(logic s, price_t p, vol_t v);
            snapshot_t want;
            want = '0;
            want.status = apply_level(s, p, v);
            if (want.status == ST_FULL) dropped_full++;
            if (want.status == ST_ABSENT) absent_deletes++;
            if (lvl_count[SIDE_BID] != 0) begin
                want.bid_present = 1'b1;
                want.bid_price   = lvl_price[SIDE_BID][lvl_count[SIDE_BID]-1];
                want.bid_volume  = lvl_vol[SIDE_BID][lvl_count[SIDE_BID]-1];
            end
            if (lvl_count[SIDE_ASK] != 0) begin
                want.ask_present = 1'b1;
                want.ask_price   = lvl_price[SIDE_ASK][0];
                want.ask_volume  = lvl_vol[SIDE_ASK][0];
            end
            want.instrument = instrument;
            pending.push_back(want);
            orders++;
        endfunction

        task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
            $display("[%0t] result %0d: %s is 0x%08h, expected 0x%08h",
                     $realtime, checked, field, got, want);
            errors++;
        endtask

        task check_snapshot(snapshot_t got);
            snapshot_t want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result, status", 32'(got.status), '0);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.status != want.status)
                report_mismatch("status", 32'(got.status), 32'(want.status));
            if (got.bid_present != want.bid_present)
                report_mismatch("bid_present", 32'(got.bid_present), 32'(want.bid_present));
            if (got.bid_price != want.bid_price)
                report_mismatch("best_bid_price", got.bid_price, want.bid_price);
            if (got.bid_volume != want.bid_volume)
                report_mismatch("best_bid_volume", got.bid_volume, want.bid_volume);
            if (got.ask_present != want.ask_present)
                report_mismatch("ask_present", 32'(got.ask_present), 32'(want.ask_present));
            if (got.ask_price != want.ask_price)
                report_mismatch("best_ask_price", got.ask_price, want.ask_price);
            if (got.ask_volume != want.ask_volume)
                report_mismatch("best_ask_volume", got.ask_volume, want.ask_volume);
            if (got.instrument != want.instrument)
                report_mismatch("instrument_out", got.instrument, want.instrument);
        endtask
    endclass

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_in_valid = 1'b0;
    logic   i_side = 1'b0;
    price_t i_price = '0;
    vol_t   i_volume = '0;
    logic   i_out_ready = 1'b0;
    logic   i_cfg_we = 1'b0;
    inst_t  i_cfg_wdata = '0;

    logic   o_in_ready;
    logic   o_out_valid;
    logic [1:0] o_status;
    logic   o_bid_present;
    price_t o_best_bid_price;
    vol_t   o_best_bid_volume;
    logic   o_ask_present;
    price_t o_best_ask_price;
    vol_t   o_best_ask_volume;
    inst_t  o_instrument_out;

    book_scoreboard book;
    bit             tx_calm = 1'b0;
    bit             long_hold_done = 1'b0;
    int unsigned    cycle_count = 0;
    int unsigned    settings_written = 0;

    price_level_order_book_top #(
        .LEVELS(DEPTH)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_side           (i_side),
        .i_price          (i_price),
        .i_volume         (i_volume),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_bid_present    (o_bid_present),
        .o_best_bid_price (o_best_bid_price),
        .o_best_bid_volume(o_best_bid_volume),
        .o_ask_present    (o_ask_present),
        .o_best_ask_price (o_best_ask_price),
        .o_best_ask_volume(o_best_ask_volume),
        .o_instrument_out (o_instrument_out),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("timed out after %0d cycles with %0d results outstanding",
                     cycle_count, book.pending.size());
            $display("price_level_order_book_top regression: fail");
            $finish;
        end
    end

    // Both channels are sampled at the clock edge, so each transaction is seen exactly once.
    always @(posedge i_clk) begin : monitor
        snapshot_t seen;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                book.note_order(i_side, i_price, i_volume);
            if (o_out_valid && i_out_ready) begin
                seen.status      = t_status'(o_status);
                seen.bid_present = o_bid_present;
                seen.bid_price   = o_best_bid_price;
                seen.bid_volume  = o_best_bid_volume;
                seen.ask_present = o_ask_present;
                seen.ask_price   = o_best_ask_price;
                seen.ask_volume  = o_best_ask_volume;
                seen.instrument  = o_instrument_out;
                book.check_snapshot(seen);
            end
        end
    end

    // Mostly short gaps, now and then a long one; a calm spell means no gaps at all.
    function automatic int unsigned pick_gap(bit calm);
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic vol_t nonzero_volume();
        int unsigned r;
        vol_t v;
        r = $urandom_range(0, 99);
        if (r < 10) return '1;
        if (r < 25) return vol_t'($urandom_range(1, 15));
        v = $urandom();
        return (v == '0) ? vol_t'(1) : v;
    endfunction

    task automatic send_order(input logic s, input price_t p, input vol_t v);
        int unsigned gap;
        if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
        gap = pick_gap(tx_calm);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_side     <= s;
        i_price    <= p;
        i_volume   <= v;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Stops offering and waits until the block has returned every result it owes.
    task automatic quiesce();
        i_in_valid <= 1'b0;
        while (book.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_instrument(input inst_t id);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= id;
        @(posedge i_clk);
        book.instrument = id;
        settings_written++;
        i_cfg_we <= 1'b0;
    endtask

    // Updates and deletes mostly land on a small set of prices so that levels are hit often.
    task automatic churn_levels(input int unsigned count, input bit clustered);
        price_t pool[$];
        int unsigned r;
        logic s;
        price_t p;
        if (!clustered) begin
            pool.push_back('0);
            pool.push_back('1);
        end
        while (pool.size() < 24)
            pool.push_back(clustered ? price_t'(1000 + $urandom_range(0, 40)) : price_t'($urandom()));
        repeat (count) begin
            r = $urandom_range(0, 99);
            s = logic'($urandom_range(0, 1));
            p = pool[$urandom_range(0, pool.size() - 1)];
            if (r < 60)
                send_order(s, p, nonzero_volume());
            else if (r < 90)
                send_order(s, p, '0);
            else
                send_order(s, price_t'($urandom()), ($urandom_range(0, 1) != 0) ? '0 : nonzero_volume());
        end
    endtask

    // Fills one side to capacity, then mixes new prices, updates and deletes around the limit.
    task automatic fill_side(input logic s);
        price_t used[$];
        price_t p;
        int unsigned r;
        int unsigned idx;
        repeat (DEPTH) begin
            p = $urandom();
            used.push_back(p);
            send_order(s, p, nonzero_volume());
        end
        repeat (50) begin
            r = $urandom_range(0, 99);
            if (r < 45 || used.size() == 0) begin
                p = $urandom();
                used.push_back(p);
                send_order(s, p, nonzero_volume());
            end else if (r < 80) begin
                send_order(s, used[$urandom_range(0, used.size() - 1)], nonzero_volume());
            end else begin
                idx = $urandom_range(0, used.size() - 1);
                send_order(s, used[idx], '0);
                used.delete(idx);
            end
        end
    endtask

    initial begin : result_sink
        int unsigned stall;
        bit calm;
        calm = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 47) == 0) calm = !calm;
            if (!long_hold_done && book.checked >= 80) begin
                // Long back-pressure while the sender keeps going, so the input must stall.
                long_hold_done = 1'b1;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                stall = pick_gap(calm);
                if (stall != 0) begin
                    i_out_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        book = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_instrument('1);

        // Deletes on an empty book, then the price and volume extremes on both sides.
        send_order(SIDE_BID, price_t'(5), '0);
        send_order(SIDE_ASK, '0, '0);
        send_order(SIDE_BID, '0, vol_t'(1));
        send_order(SIDE_BID, '1, '1);
        send_order(SIDE_BID, price_t'(100), vol_t'(7));
        send_order(SIDE_ASK, '1, vol_t'(1));
        send_order(SIDE_ASK, '0, '1);
        send_order(SIDE_ASK, price_t'(50), vol_t'(3));
        send_order(SIDE_BID, '1, vol_t'(32'h1234_5678));
        send_order(SIDE_ASK, '0, vol_t'(5));
        send_order(SIDE_BID, price_t'(101), '0);
        send_order(SIDE_BID, '1, '0);
        send_order(SIDE_BID, price_t'(100), '0);
        send_order(SIDE_BID, '0, '0);
        send_order(SIDE_ASK, '0, '0);
        send_order(SIDE_ASK, price_t'(50), '0);
        send_order(SIDE_ASK, '1, '0);
        send_order(SIDE_ASK, price_t'(32'h8000_0000), vol_t'(32'h8000_0000));
        send_order(SIDE_BID, price_t'(32'h7FFF_FFFF), vol_t'(32'h7FFF_FFFF));
        send_order(SIDE_ASK, price_t'(32'h8000_0000), '0);
        send_order(SIDE_BID, price_t'(32'h7FFF_FFFF), '0);

        quiesce();
        write_instrument('0);
        churn_levels(220, 1'b0);

        quiesce();
        write_instrument(inst_t'($urandom()));
        fill_side(SIDE_BID);
        fill_side(SIDE_ASK);

        quiesce();
        write_instrument(inst_t'($urandom()));
        churn_levels(140, 1'b1);

        quiesce();
        repeat (8) @(posedge i_clk);
        $display("%0d orders checked over %0d instrument settings, with back-pressure stalls;",
                 book.checked, settings_written);
        $display("%0d inserts dropped on a full side, %0d deletes of absent levels, %0d mismatches",
                 book.dropped_full, book.absent_deletes, book.errors);
        if (book.errors == 0) begin
            $display("price_level_order_book_top regression: pass");
        end else begin
            $display("price_level_order_book_top regression: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire
